FILE: hw/rtl/pff_pkg.sv
// Shared types and constants for the Pareto front filter.
package pff_pkg;

    // Default configuration
    localparam int MAX_POINTS_DEF = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths of the item channels
    localparam int COORD_BITS = 32;
    localparam int PIDX_BITS  = 6;
    localparam int SCNT_BITS  = 7;

    // Input item: one point
    typedef struct packed {
        logic [COORD_BITS-1:0] strength;
        logic [COORD_BITS-1:0] cost;
        logic                  last_point;
    } t_in_item;

    // Output item: one survivor
    typedef struct packed {
        logic [PIDX_BITS-1:0] point_index;
        logic [SCNT_BITS-1:0] survivor_count;
        logic                 overflow;
        logic                 last_result;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load_en;     // take input items into the store
        logic start_eval;  // clear point and survivor counters
        logic read_i;      // read the candidate point
        logic latch_pi;    // capture the candidate point, restart the scan
        logic scan;        // read the next challenger point
        logic finish_i;    // record the candidate's mark, step to next
        logic emit_step;   // offer the next mark to the output register
        logic end_set;     // clear set state after the final emission
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic acc_last;    // point with last_point accepted this cycle
        logic j_at_end;    // challenger index is the last stored point
        logic i_at_end;    // candidate index is the last stored point
        logic out_free;    // output register can take an item this cycle
    } t_dp_status;

endpackage

FILE: hw/rtl/pff_ctrl.sv
// Sequencer for loading, pairwise evaluation and survivor emission.
module pff_ctrl
    import pff_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_READI = 6'b000010,
        S_LATCH = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                o_cmd.load_en = 1'b1;
                if (i_status.acc_last) begin
                    o_cmd.start_eval = 1'b1;
                    n_state          = S_READI;
                end
            end
            S_READI: begin
                o_cmd.read_i = 1'b1;
                n_state      = S_LATCH;
            end
            S_LATCH: begin
                o_cmd.latch_pi = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.j_at_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.finish_i = 1'b1;
                n_state        = i_status.i_at_end ? S_EMIT : S_READI;
            end
            S_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_status.out_free && i_status.i_at_end) begin
                    o_cmd.end_set = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/pff_datapath.sv
// Point store, dominance comparator, counters and output register.
module pff_datapath
    import pff_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    // Point store
    logic [VALUE_BITS-1:0] mem_s [MAX_POINTS];
    logic [VALUE_BITS-1:0] mem_c [MAX_POINTS];
    logic [VALUE_BITS-1:0] r_rd_s, r_rd_c;
    logic [IDX_W-1:0]      rd_addr;

    // Set state and counters
    logic [CNT_W-1:0]      r_count;
    logic                  r_overflow;
    logic [MAX_POINTS-1:0] r_marks;
    logic [IDX_W-1:0]      r_i, r_j, r_cmp_j;
    logic                  r_cmp_valid;
    logic                  r_dom;
    logic [CNT_W-1:0]      r_surv, r_emitted;
    logic [VALUE_BITS-1:0] r_pi_s, r_pi_c;

    // Output register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic             accept;
    logic             hit;
    logic             dom_final;
    logic             out_free;
    logic             survivor;
    logic             store_room;
    logic [IDX_W-1:0] last_idx;

    assign o_in_ready = i_cmd.load_en;
    assign accept     = i_in_valid & i_cmd.load_en;
    assign store_room = (r_count < CNT_W'(MAX_POINTS));
    assign last_idx   = IDX_W'(r_count - CNT_W'(1));
    assign out_free   = !r_out_valid || i_out_ready;
    assign survivor   = !r_marks[r_i];
    assign rd_addr    = i_cmd.read_i ? r_i : r_j;

    // Challenger dominates candidate: not weaker and strictly cheaper
    assign hit = r_cmp_valid && (r_cmp_j != r_i) &&
                 (r_rd_s >= r_pi_s) && (r_rd_c < r_pi_c);
    assign dom_final = r_dom | hit;

    assign o_status.acc_last = accept & i_in_item.last_point;
    assign o_status.j_at_end = (r_j == last_idx);
    assign o_status.i_at_end = (r_i == last_idx);
    assign o_status.out_free = out_free;

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (accept && store_room) begin
            mem_s[r_count[IDX_W-1:0]] <= VALUE_BITS'(i_in_item.strength);
            mem_c[r_count[IDX_W-1:0]] <= VALUE_BITS'(i_in_item.cost);
        end
        r_rd_s <= mem_s[rd_addr];
        r_rd_c <= mem_c[rd_addr];
    end

    // Load count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.end_set) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (accept) begin
            if (store_room) begin
                r_count <= r_count + CNT_W'(1);
            end else begin
                r_overflow <= 1'b1;
            end
        end
    end

    // Evaluation and emission counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= '0;
            r_j         <= '0;
            r_cmp_valid <= 1'b0;
            r_dom       <= 1'b0;
            r_surv      <= '0;
            r_emitted   <= '0;
            r_marks     <= '0;
        end else begin
            r_cmp_valid <= i_cmd.scan;
            if (i_cmd.start_eval) begin
                r_i       <= '0;
                r_surv    <= '0;
                r_emitted <= '0;
            end
            if (i_cmd.latch_pi) begin
                r_j   <= '0;
                r_dom <= 1'b0;
            end else begin
                r_dom <= dom_final;
            end
            if (i_cmd.scan) begin
                r_j <= r_j + IDX_W'(1);
            end
            if (i_cmd.finish_i) begin
                r_marks[r_i] <= dom_final;
                if (!dom_final) begin
                    r_surv <= r_surv + CNT_W'(1);
                end
                r_i <= o_status.i_at_end ? '0 : r_i + IDX_W'(1);
            end
            if (i_cmd.emit_step && out_free) begin
                if (survivor) begin
                    r_emitted <= r_emitted + CNT_W'(1);
                end
                r_i <= o_status.i_at_end ? '0 : r_i + IDX_W'(1);
            end
        end
    end

    // Candidate point capture and compare index pipeline
    always_ff @(posedge i_clk) begin
        r_cmp_j <= r_j;
        if (i_cmd.latch_pi) begin
            r_pi_s <= r_rd_s;
            r_pi_c <= r_rd_c;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_cmd.emit_step && survivor;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_step && out_free && survivor) begin
            r_out_item.point_index    <= PIDX_BITS'(r_i);
            r_out_item.survivor_count <= SCNT_BITS'(r_surv);
            r_out_item.overflow       <= r_overflow;
            r_out_item.last_result    <= ((r_emitted + CNT_W'(1)) == r_surv);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: hw/rtl/pareto_front_filter_core.sv
// Top level of the Pareto front filter: controller and datapath.
// Points are taken one per cycle into an on-chip store of MAX_POINTS entries;
// points beyond capacity are dropped and the set is flagged as overflowed.
// The point marked last_point starts evaluation, during which no input is
// taken: each of the n stored points is checked against every other stored
// point through the store's single registered read port. Survivors then leave
// in ascending arrival order, one stored point examined per cycle while the
// output is not stalled, each with the survivor count, the overflow flag and
// a final-item mark. Loading of the next set resumes in the cycle after the
// last stored point has been examined.
module pareto_front_filter_core
    import pff_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer
    pff_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Store, comparator and output stage
    pff_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
